// File: rtl/pfir_pkg.sv
`default_nettype none
package pfir_pkg;

  localparam int DEF_TAPS   = 10;
  localparam int REG_TAPS   = 10;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 15;
  localparam int STEP_W     = 9;
  localparam int PHASE_W    = 8;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_MAX   = 256;

  localparam logic [COEF_W-1:0] TAP_RESET = 16'h0CCD;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    CFG_TAPS_0_3 = 2'd0,
    CFG_TAPS_4_7 = 2'd1,
    CFG_TAPS_8_9 = 2'd2,
    CFG_STEP     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    sample_t sample;
    logic    frame_start;
  } sample_word_t;

  typedef struct packed {
    sample_t filtered_value;
    logic    freshly_computed;
  } result_t;

  typedef struct packed {
    logic valid;
    logic fresh;
  } stage_ctl_t;

  function automatic cfg_idx_t tap_reg(input int k);
    cfg_idx_t r;
    if (k < 4) begin
      r = CFG_TAPS_0_3;
    end else if (k < 8) begin
      r = CFG_TAPS_4_7;
    end else begin
      r = CFG_TAPS_8_9;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pfir_cell.sv
`default_nettype none
module pfir_cell (
  input  wire logic                    clk,
  input  wire logic                    shift,
  input  wire logic                    load,
  input  wire pfir_pkg::sample_t       sample_in,
  input  wire pfir_pkg::coef_t         coef,
  output pfir_pkg::sample_t            sample,
  output logic signed [pfir_pkg::SAMPLE_W+pfir_pkg::COEF_W-1:0] prod
);

  // window cell: sample moves one place toward the oldest tap per accepted word
  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= sample_in;
    end
    if (load) begin
      prod <= sample * coef;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pfir_out.sv
`default_nettype none
module pfir_out #(
  parameter int ACC_W = 36
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pfir_pkg::stage_ctl_t    ctl,
  input  wire logic signed [ACC_W-1:0] acc,
  input  wire logic                    res_stall,
  output logic                         ready,
  output logic                         res_valid,
  output pfir_pkg::result_t            res_data
);

  localparam int QW = ACC_W - pfir_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (pfir_pkg::FRAC_BITS - 1));
  localparam logic signed [QW-1:0] Q_MAX = QW'(2 ** (pfir_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -(QW'(2 ** (pfir_pkg::SAMPLE_W - 1)));

  logic signed [ACC_W-1:0] rounded;
  logic signed [QW-1:0]    q;
  pfir_pkg::sample_t       sat;
  pfir_pkg::sample_t       held;

  assign rounded = acc + HALF;
  assign q       = rounded[ACC_W-1:pfir_pkg::FRAC_BITS];

  always_comb begin
    if (q > Q_MAX) begin
      sat = Q_MAX[pfir_pkg::SAMPLE_W-1:0];
    end else if (q < Q_MIN) begin
      sat = Q_MIN[pfir_pkg::SAMPLE_W-1:0];
    end else begin
      sat = q[pfir_pkg::SAMPLE_W-1:0];
    end
  end

  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      held      <= '0;
    end else if (ready) begin
      res_valid <= ctl.valid;
      if (ctl.valid) begin
        if (ctl.fresh) begin
          held <= sat;
        end
        res_data.filtered_value   <= ctl.fresh ? sat : held;
        res_data.freshly_computed <= ctl.fresh;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/perforated_fir_filter_unit.sv
// Pipeline: a result word is built from its sample word through the window
//   cell, tap products, adder tree and round/saturate output registers.
// Throughput: one sample word per cycle; the input stalls only while a blocked
//   result has all three stages behind it full.
// Reset (rst, synchronous, active high): taps to 0x0CCD, step to 1, window
//   empty, phase and held value zero, no result pending.
`default_nettype none
module perforated_fir_filter_unit #(
  parameter int TAPS = pfir_pkg::DEF_TAPS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   smp_valid,
  output logic                        smp_stall,
  input  wire pfir_pkg::sample_word_t smp_data,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output pfir_pkg::result_t           res_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire pfir_pkg::cfg_idx_t     cfg_index,
  input  wire logic [pfir_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ACC_W  = pfir_pkg::SAMPLE_W + pfir_pkg::COEF_W + $clog2(TAPS);
  localparam int PROD_W = pfir_pkg::SAMPLE_W + pfir_pkg::COEF_W;
  localparam int LVLS   = $clog2(TAPS);
  localparam int TREE_N = 2 ** LVLS;
  localparam int FILL_W = $clog2(TAPS);
  localparam int STEP_W = pfir_pkg::STEP_W;
  localparam int PH_W   = pfir_pkg::PHASE_W;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS - 1);

  pfir_pkg::coef_t          tap [TAPS];
  pfir_pkg::sample_t        win [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [ACC_W-1:0]  tree [LVLS+1][TREE_N];
  logic signed [ACC_W-1:0]  sum;
  logic [STEP_W-1:0]       step_raw;
  logic [STEP_W-1:0]       step_eff;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_cur;
  logic [PH_W-1:0]         phase;
  logic [PH_W-1:0]         phase_cur;
  logic [PH_W-1:0]         phase_inc;
  logic                    smp_acc;
  logic                    produce;
  logic                    out_ready;
  logic                    adv1;
  logic                    adv2;
  logic                    adv3;
  pfir_pkg::stage_ctl_t    s1;
  pfir_pkg::stage_ctl_t    s2;
  pfir_pkg::stage_ctl_t    s3;

  assign cfg_ready = 1'b1;

  genvar k;
  generate
    for (k = 0; k < TAPS; k++) begin : g_tap
      if (k < pfir_pkg::REG_TAPS) begin : g_reg
        localparam int OFF = (k % 4) * pfir_pkg::COEF_W;
        always_ff @(posedge clk) begin
          if (rst) begin
            tap[k] <= pfir_pkg::TAP_RESET;
          end else if (cfg_valid && cfg_index == pfir_pkg::tap_reg(k)) begin
            tap[k] <= cfg_data[OFF +: pfir_pkg::COEF_W];
          end
        end
      end else begin : g_zero
        assign tap[k] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      step_raw <= STEP_W'(1);
    end else if (cfg_valid && cfg_index == pfir_pkg::CFG_STEP) begin
      step_raw <= cfg_data[STEP_W-1:0];
    end
  end

  always_comb begin
    if (step_raw == '0) begin
      step_eff = STEP_W'(1);
    end else if (step_raw > STEP_W'(pfir_pkg::STEP_MAX)) begin
      step_eff = STEP_W'(pfir_pkg::STEP_MAX);
    end else begin
      step_eff = step_raw;
    end
  end

  assign adv3      = !s3.valid || out_ready;
  assign adv2      = !s2.valid || adv3;
  assign adv1      = !s1.valid || adv2;
  assign smp_stall = !adv1;
  assign smp_acc   = smp_valid && !smp_stall;

  assign fill_cur  = smp_data.frame_start ? '0 : fill;
  assign phase_cur = smp_data.frame_start ? '0 : phase;
  assign produce   = (fill_cur == FILL_FULL);
  assign phase_inc = phase_cur + PH_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      phase <= '0;
      s1    <= '0;
      s2    <= '0;
      s3    <= '0;
    end else begin
      if (smp_acc) begin
        if (!produce) begin
          fill  <= fill_cur + FILL_W'(1);
          phase <= phase_cur;
        end else begin
          fill  <= fill_cur;
          phase <= ({1'b0, phase_inc} >= step_eff) ? '0 : phase_inc;
        end
      end
      if (adv1) begin
        s1.valid <= smp_acc && produce;
        s1.fresh <= phase_cur == '0;
      end
      if (adv2) begin
        s2 <= s1;
      end
      if (adv3) begin
        s3 <= s2;
      end
    end
  end

  generate
    for (k = 0; k < TAPS; k++) begin : g_cell
      pfir_pkg::sample_t nxt;
      if (k == TAPS - 1) begin : g_last
        assign nxt = smp_data.sample;
      end else begin : g_next
        assign nxt = win[k+1];
      end
      pfir_cell u_cell (
        .clk      (clk),
        .shift    (smp_acc),
        .load     (adv2),
        .sample_in(nxt),
        .coef     (tap[k]),
        .sample   (win[k]),
        .prod     (prod[k])
      );
    end
  endgenerate

  // balanced adder tree over the registered tap products
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        tree[l][i] = '0;
      end
    end
    for (int i = 0; i < TAPS; i++) begin
      tree[0][i] = {{(ACC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        tree[l+1][i] = tree[l][2*i] + tree[l][2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sum <= tree[LVLS][0];
    end
  end

  pfir_out #(
    .ACC_W(ACC_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (s3),
    .acc      (sum),
    .res_stall(res_stall),
    .ready    (out_ready),
    .res_valid(res_valid),
    .res_data (res_data)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count beyond window size");

  a_frame_refill: assert property (@(posedge clk) disable iff (rst)
    smp_acc && smp_data.frame_start |=> fill == FILL_W'(1) && !s1.valid)
    else $error("frame start did not restart the window fill");

  a_fresh_phase: assert property (@(posedge clk) disable iff (rst)
    smp_acc && produce && phase_cur == '0 |=> s1.valid && s1.fresh)
    else $error("phase zero word not marked fresh");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s3.valid && res_valid && res_stall |=> $stable(sum))
    else $error("sum moved while a result was blocked");

endmodule
`default_nettype wire
